// ===== rtl/ps2_set2_key_tracker_macros.svh =====
// assertion macros shared by the key tracker rtl
// depends on nothing; included inside module bodies
`ifndef PS2_SET2_KEY_TRACKER_MACROS_SVH
`define PS2_SET2_KEY_TRACKER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define PS2KT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ps2kt assertion failed");

// next-cycle implication, disabled while in reset
`define PS2KT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ps2kt assertion failed");

`endif

// ===== rtl/ps2kt_pkg.sv =====
// types, constants and the scan code table of the key tracker
// depends on nothing
package ps2kt_pkg;

    localparam logic [7:0]  PREFIX_EXT    = 8'hE0;
    localparam logic [7:0]  PREFIX_BRK    = 8'hF0;
    localparam logic [15:0] HOLDOFF_RESET = 16'd100;

    localparam logic [1:0] OP_SCAN  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PREFIX  = 2'd1,
        PH_EXT_BRK = 2'd2
    } phase_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] scan_byte;
        logic [6:0] query_key;
    } item_t;

    typedef struct packed {
        logic       valid;
        logic [6:0] key;
        logic       brk;
    } evt_t;

    typedef struct packed {
        logic       event_valid;
        logic [6:0] key_code;
        logic       is_release;
        logic       press_accepted;
        logic       key_pressed;
    } result_t;

    function automatic logic [6:0] map_key(input logic ext, input logic [7:0] code);
        logic [6:0] ch;
        unique case (code)
            8'h0E: ch = 7'h60;
            8'h16: ch = 7'h31;
            8'h1E: ch = 7'h32;
            8'h26: ch = 7'h33;
            8'h25: ch = 7'h34;
            8'h2E: ch = 7'h35;
            8'h36: ch = 7'h36;
            8'h3D: ch = 7'h37;
            8'h3E: ch = 7'h38;
            8'h46: ch = 7'h39;
            8'h45: ch = 7'h30;
            8'h4E: ch = 7'h2D;
            8'h55: ch = 7'h3D;
            8'h15: ch = 7'h51;
            8'h1D: ch = 7'h57;
            8'h24: ch = 7'h45;
            8'h2D: ch = 7'h52;
            8'h2C: ch = 7'h54;
            8'h35: ch = 7'h59;
            8'h3C: ch = 7'h55;
            8'h43: ch = 7'h49;
            8'h44: ch = 7'h4F;
            8'h4D: ch = 7'h50;
            8'h54: ch = 7'h5B;
            8'h5B: ch = 7'h5D;
            8'h1C: ch = 7'h41;
            8'h1B: ch = 7'h53;
            8'h23: ch = 7'h44;
            8'h2B: ch = 7'h46;
            8'h34: ch = 7'h47;
            8'h33: ch = 7'h48;
            8'h3B: ch = 7'h4A;
            8'h42: ch = 7'h4B;
            8'h4B: ch = 7'h4C;
            8'h4C: ch = 7'h3B;
            8'h52: ch = 7'h27;
            8'h5D: ch = 7'h5C;
            8'h1A: ch = 7'h5A;
            8'h22: ch = 7'h58;
            8'h21: ch = 7'h43;
            8'h2A: ch = 7'h56;
            8'h32: ch = 7'h42;
            8'h31: ch = 7'h4E;
            8'h3A: ch = 7'h4D;
            8'h41: ch = 7'h2C;
            8'h49: ch = 7'h2E;
            8'h4A: ch = 7'h2F;
            8'h29: ch = 7'h20;
            8'h5A: ch = 7'h0A;
            8'h0D: ch = 7'h09;
            8'h66: ch = 7'h08;
            8'h76: ch = 7'h1B;
            default: ch = 7'h00;
        endcase
        // extended arrow keys
        if (ext)
        begin
            unique case (code)
                8'h75: ch = 7'h5E;
                8'h72: ch = 7'h76;
                8'h6B: ch = 7'h3C;
                8'h74: ch = 7'h3E;
                default: ch = ch;
            endcase
        end
        return ch;
    endfunction

endpackage

// ===== rtl/ps2kt_decode.sv =====
// scan byte assembly: prefix tracking and mapping of completed events
// depends on ps2kt_pkg and the macros header
module ps2kt_decode (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  ps2kt_pkg::item_t item,
    output ps2kt_pkg::evt_t  evt
);
    import ps2kt_pkg::*;

    phase_t phase_reg;
    phase_t phase_next;
    logic   prefix_ext_reg;
    logic   prefix_ext_next;
    logic   is_scan;
    logic   is_prefix;
    logic   have;
    logic   ext;
    logic   brk;
    logic [6:0] ch;

    assign is_scan   = (item.op == OP_SCAN);
    assign is_prefix = (item.scan_byte == PREFIX_EXT) || (item.scan_byte == PREFIX_BRK);

    // next state
    always_comb
    begin
        phase_next      = phase_reg;
        prefix_ext_next = prefix_ext_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (is_prefix)
                begin
                    phase_next      = PH_PREFIX;
                    prefix_ext_next = (item.scan_byte == PREFIX_EXT);
                end
            end
            PH_PREFIX:
            begin
                if (prefix_ext_reg && item.scan_byte == PREFIX_BRK)
                begin
                    phase_next = PH_EXT_BRK;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_EXT_BRK: phase_next = PH_IDLE;
            default:    phase_next = PH_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        have = 1'b0;
        ext  = 1'b0;
        brk  = 1'b0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                have = !is_prefix;
            end
            PH_PREFIX:
            begin
                if (prefix_ext_reg)
                begin
                    have = (item.scan_byte != PREFIX_BRK);
                    ext  = 1'b1;
                end
                else
                begin
                    have = 1'b1;
                    brk  = 1'b1;
                end
            end
            PH_EXT_BRK:
            begin
                have = 1'b1;
                ext  = 1'b1;
                brk  = 1'b1;
            end
            default:
            begin
                have = 1'b0;
            end
        endcase
    end

    assign ch        = map_key(ext, item.scan_byte);
    assign evt.valid = is_scan && have && (ch != 7'd0);
    assign evt.key   = ch;
    assign evt.brk   = brk;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            prefix_ext_reg <= 1'b0;
        end
        else if (fire && is_scan)
        begin
            phase_reg      <= phase_next;
            prefix_ext_reg <= prefix_ext_next;
        end
    end

`include "ps2_set2_key_tracker_macros.svh"

    `PS2KT_ASSERT_IMPL(a_ext_brk_needs_e0, clk, rst_n, phase_reg == PH_EXT_BRK, prefix_ext_reg)

endmodule

// ===== rtl/ps2kt_keystate.sv =====
// pressed table, hold-off counter and hold-off register
// depends on ps2kt_pkg and the macros header
module ps2kt_keystate #(
    parameter int KEY_COUNT = 128
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_data,
    input  logic               fire,
    input  logic [1:0]         op,
    input  logic [6:0]         query_key,
    input  ps2kt_pkg::evt_t    evt,
    output ps2kt_pkg::result_t res
);
    import ps2kt_pkg::*;

    localparam int KEY_W = $clog2(KEY_COUNT);

    logic [KEY_COUNT-1:0] pressed_reg;
    logic [15:0]          ticks_reg;
    logic [15:0]          count_reg;
    logic [15:0]          count_next;
    logic                 press_ok;
    logic [KEY_W-1:0]     evt_idx;
    logic [KEY_W-1:0]     query_idx;

    assign press_ok  = !evt.brk && (count_reg == 16'd0);
    assign evt_idx   = KEY_W'(evt.key);
    assign query_idx = KEY_W'(query_key);

    always_comb
    begin
        count_next = count_reg;
        if (evt.valid && press_ok)
        begin
            count_next = ticks_reg;
        end
        else if (op == OP_TICK && count_reg != 16'd0)
        begin
            count_next = count_reg - 16'd1;
        end
    end

    always_comb
    begin
        res = '0;
        if (evt.valid)
        begin
            res.event_valid    = 1'b1;
            res.key_code       = evt.key;
            res.is_release     = evt.brk;
            res.press_accepted = press_ok;
            res.key_pressed    = press_ok;
        end
        else if (op == OP_QUERY)
        begin
            res.key_code    = query_key;
            res.key_pressed = pressed_reg[query_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= HOLDOFF_RESET;
        end
        else if (cfg_we)
        begin
            ticks_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg <= '0;
            count_reg   <= 16'd0;
        end
        else if (fire)
        begin
            count_reg <= count_next;
            if (evt.valid)
            begin
                pressed_reg[evt_idx] <= press_ok;
            end
        end
    end

`include "ps2_set2_key_tracker_macros.svh"

    `PS2KT_ASSERT_NEXT(a_reload, clk, rst_n, fire && evt.valid && press_ok, count_reg == $past(ticks_reg))
    `PS2KT_ASSERT_NEXT(a_count_no_rise, clk, rst_n, !(fire && evt.valid && press_ok), count_reg <= $past(count_reg))

endmodule

// ===== rtl/ps2_set2_key_tracker.sv =====
// top level of the ps/2 set 2 key tracker: stream ports, input and result registers
// depends on ps2kt_pkg, ps2kt_decode, ps2kt_keystate and the macros header

// Takes one transaction per clock cycle, sustained while m_tready does not hold the result
// register, whatever the operation: a scan byte, a hold-off tick or a key query. A result
// passes through the input register and then the result register, with one result per
// input; the decode and table update run in a single pass between those two registers.
// The pressed table is KEY_COUNT flip-flops cleared directly by reset, so the block is
// ready right after reset with no clearing pass. The hold-off register is written over
// the cfg channel, which is always ready; write it only while no transaction is in flight.
module ps2_set2_key_tracker #(
    parameter int KEY_COUNT = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,      // holdoff_ticks
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,       // scan_byte [7:0], query_key [14:8]
    input  logic [1:0]  s_tuser,       // operation [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,       // key_code [6:0], is_release [7], press_accepted [8],
                                       // key_pressed [9]
    output logic        m_tuser        // event_valid [0]
);
    import ps2kt_pkg::*;

    item_t   item_reg;
    logic    in_valid_reg;
    logic    in_valid_next;
    result_t res_reg;
    result_t res;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    fire;
    logic    take;
    evt_t    evt;

    assign fire      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || fire;
    assign take      = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign in_valid_next  = take ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
    assign out_valid_next = fire ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    ps2kt_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .evt   (evt)
    );

    ps2kt_keystate #(
        .KEY_COUNT (KEY_COUNT)
    ) u_keystate (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .op        (item_reg.op),
        .query_key (item_reg.query_key),
        .evt       (evt),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.op        <= s_tuser;
            item_reg.scan_byte <= s_tdata[7:0];
            item_reg.query_key <= s_tdata[14:8];
        end
        if (fire)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.event_valid;
    assign m_tdata  = {6'd0, res_reg.key_pressed, res_reg.press_accepted,
                       res_reg.is_release, res_reg.key_code};

`include "ps2_set2_key_tracker_macros.svh"

    `PS2KT_ASSERT_IMPL(a_event_has_key, clk, rst_n, out_valid_reg && res_reg.event_valid, res_reg.key_code != 7'd0)
    `PS2KT_ASSERT_IMPL(a_accept_is_press, clk, rst_n, out_valid_reg && res_reg.press_accepted, res_reg.key_pressed && !res_reg.is_release && res_reg.event_valid)

endmodule

// ===== test/ps2_set2_key_tracker_tb.sv =====
`timescale 1ns / 1ps
// testbench of ps2_set2_key_tracker: directed, then random scan byte, tick, query and unused
// operation transactions, each result checked field by field against an in-bench key tracker
// depends on ps2kt_pkg and the rtl of ps2_set2_key_tracker
module ps2_set2_key_tracker_tb;
    import ps2kt_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [7:0] SC_UP     = 8'h75;
    localparam logic [7:0] SC_DOWN   = 8'h72;
    localparam logic [7:0] SC_LEFT   = 8'h6B;
    localparam logic [7:0] SC_RIGHT  = 8'h74;
    localparam int STALL_MAX      = 15;
    localparam int RX_HOLD_AT     = 300;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int QUIET_NEEDED   = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 185;
    localparam int BURST_ITEMS    = 30;

    typedef enum logic [1:0] {ST_ITEM, ST_CFG, ST_DRAIN} stim_kind_t;

    typedef struct {
        stim_kind_t  kind;
        item_t       item;
        logic [15:0] cfg;
        int          gap;
    } stim_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [15:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic [15:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tready  = 1'b0;
    logic        cfg_ready;
    logic        s_tready;
    logic        m_tvalid;
    logic [15:0] m_tdata;
    logic        m_tuser;

    // key tracker predictor state
    phase_t      scan_phase;
    logic [7:0]  held_prefix;
    logic        pressed_keys [128];
    logic [15:0] holdoff_left;
    logic [15:0] holdoff_load;

    stim_t   stim_q [$];
    result_t tracker_results [$];
    item_t   cur_item;
    int      items_queued = 0;
    int      burst = 0;
    int      send_gap = 0;
    int      quiet_cycles = 0;
    int      recv_stall = 0;
    int      hold_left = 0;
    int      results_seen = 0;
    int      error_count = 0;

    ps2_set2_key_tracker #(
        .KEY_COUNT (128)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [6:0] set2_ascii(input logic [7:0] code);
        case (code)
            8'h0E: return 7'h60;  8'h16: return 7'h31;  8'h1E: return 7'h32;
            8'h26: return 7'h33;  8'h25: return 7'h34;  8'h2E: return 7'h35;
            8'h36: return 7'h36;  8'h3D: return 7'h37;  8'h3E: return 7'h38;
            8'h46: return 7'h39;  8'h45: return 7'h30;  8'h4E: return 7'h2D;
            8'h55: return 7'h3D;  8'h15: return 7'h51;  8'h1D: return 7'h57;
            8'h24: return 7'h45;  8'h2D: return 7'h52;  8'h2C: return 7'h54;
            8'h35: return 7'h59;  8'h3C: return 7'h55;  8'h43: return 7'h49;
            8'h44: return 7'h4F;  8'h4D: return 7'h50;  8'h54: return 7'h5B;
            8'h5B: return 7'h5D;  8'h1C: return 7'h41;  8'h1B: return 7'h53;
            8'h23: return 7'h44;  8'h2B: return 7'h46;  8'h34: return 7'h47;
            8'h33: return 7'h48;  8'h3B: return 7'h4A;  8'h42: return 7'h4B;
            8'h4B: return 7'h4C;  8'h4C: return 7'h3B;  8'h52: return 7'h27;
            8'h5D: return 7'h5C;  8'h1A: return 7'h5A;  8'h22: return 7'h58;
            8'h21: return 7'h43;  8'h2A: return 7'h56;  8'h32: return 7'h42;
            8'h31: return 7'h4E;  8'h3A: return 7'h4D;  8'h41: return 7'h2C;
            8'h49: return 7'h2E;  8'h4A: return 7'h2F;  8'h29: return 7'h20;
            8'h5A: return 7'h0A;  8'h0D: return 7'h09;  8'h66: return 7'h08;
            8'h76: return 7'h1B;
            default: return 7'h00;
        endcase
    endfunction

    function automatic logic [6:0] key_ascii(input logic ext, input logic [7:0] code);
        if (ext)
        begin
            case (code)
                SC_UP:    return 7'h5E;
                SC_DOWN:  return 7'h76;
                SC_LEFT:  return 7'h3C;
                SC_RIGHT: return 7'h3E;
                default:  return set2_ascii(code);
            endcase
        end
        return set2_ascii(code);
    endfunction

    task automatic reset_tracker();
        scan_phase   = PH_IDLE;
        held_prefix  = '0;
        holdoff_left = '0;
        holdoff_load = HOLDOFF_RESET;
        for (int k = 0; k < 128; k++)
            pressed_keys[k] = 1'b0;
    endtask

    function automatic result_t tracker_step(input item_t it);
        result_t    r;
        logic       have;
        logic       ext;
        logic       brk;
        logic [6:0] ch;
        r    = '0;
        have = 1'b0;
        ext  = 1'b0;
        brk  = 1'b0;
        case (it.op)
            OP_SCAN:
            begin
                case (scan_phase)
                    PH_IDLE:
                    begin
                        if (it.scan_byte == PREFIX_EXT || it.scan_byte == PREFIX_BRK)
                        begin
                            held_prefix = it.scan_byte;
                            scan_phase  = PH_PREFIX;
                        end
                        else
                            have = 1'b1;
                    end
                    PH_PREFIX:
                    begin
                        scan_phase = PH_IDLE;
                        have = 1'b1;
                        if (held_prefix == PREFIX_EXT)
                        begin
                            if (it.scan_byte == PREFIX_BRK)
                            begin
                                scan_phase = PH_EXT_BRK;
                                have = 1'b0;
                            end
                            else
                                ext = 1'b1;
                        end
                        else if (held_prefix == PREFIX_BRK)
                            brk = 1'b1;
                    end
                    PH_EXT_BRK:
                    begin
                        scan_phase = PH_IDLE;
                        have = 1'b1;
                        ext  = 1'b1;
                        brk  = 1'b1;
                    end
                    default:
                        scan_phase = PH_IDLE;
                endcase
                ch = key_ascii(ext, it.scan_byte);
                if (have && ch != 7'h00)
                begin
                    r.event_valid = 1'b1;
                    r.key_code    = ch;
                    if (brk)
                    begin
                        r.is_release     = 1'b1;
                        pressed_keys[ch] = 1'b0;
                    end
                    else if (holdoff_left == 16'd0)
                    begin
                        pressed_keys[ch]  = 1'b1;
                        holdoff_left      = holdoff_load;
                        r.press_accepted  = 1'b1;
                    end
                    else
                        pressed_keys[ch] = 1'b0;
                    r.key_pressed = pressed_keys[ch];
                end
            end
            OP_TICK:
            begin
                if (holdoff_left != 16'd0)
                    holdoff_left = holdoff_left - 16'd1;
            end
            OP_QUERY:
            begin
                r.key_code    = it.query_key;
                r.key_pressed = pressed_keys[it.query_key];
            end
            default:
                ;
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s expected %0h got %0h", name, want, got);
            error_count++;
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        logic  nxt_valid;
        logic  nxt_cfg;
        logic [15:0] nxt_cfg_data;
        item_t nxt_item;
        stim_t head;
        if (!rst_n)
        begin
            reset_tracker();
            send_gap     = 0;
            quiet_cycles = 0;
            s_tvalid  <= 1'b0;
            cfg_valid <= 1'b0;
        end
        else
        begin
            nxt_valid    = s_tvalid;
            nxt_cfg      = cfg_valid;
            nxt_cfg_data = cfg_data;
            nxt_item     = cur_item;
            if (s_tvalid && s_tready)
            begin
                tracker_results.push_back(tracker_step(cur_item));
                nxt_valid = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                holdoff_load = cfg_data;
                nxt_cfg = 1'b0;
            end
            if (s_tvalid || cfg_valid || tracker_results.size() != 0)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (!nxt_valid && !nxt_cfg)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (stim_q.size() != 0)
                begin
                    head = stim_q[0];
                    case (head.kind)
                        ST_ITEM:
                        begin
                            nxt_item  = head.item;
                            nxt_valid = 1'b1;
                            send_gap  = head.gap;
                            void'(stim_q.pop_front());
                        end
                        ST_CFG:
                        begin
                            if (quiet_cycles >= QUIET_NEEDED)
                            begin
                                nxt_cfg      = 1'b1;
                                nxt_cfg_data = head.cfg;
                                void'(stim_q.pop_front());
                            end
                        end
                        default:
                        begin
                            if (quiet_cycles >= QUIET_NEEDED)
                                void'(stim_q.pop_front());
                        end
                    endcase
                end
            end
            cur_item = nxt_item;
            s_tvalid  <= nxt_valid;
            s_tdata   <= {1'b0, nxt_item.query_key, nxt_item.scan_byte};
            s_tuser   <= nxt_item.op;
            cfg_valid <= nxt_cfg;
            cfg_data  <= nxt_cfg_data;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        result_t want;
        logic    nxt_ready;
        if (!rst_n)
        begin
            recv_stall = 0;
            hold_left  = 0;
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (tracker_results.size() == 0)
                begin
                    $error("result transaction with no expected result waiting");
                    error_count++;
                end
                else
                begin
                    want = tracker_results.pop_front();
                    check_field("event_valid", want.event_valid, m_tuser);
                    check_field("key_code", want.key_code, m_tdata[6:0]);
                    check_field("is_release", want.is_release, m_tdata[7]);
                    check_field("press_accepted", want.press_accepted, m_tdata[8]);
                    check_field("key_pressed", want.key_pressed, m_tdata[9]);
                end
                results_seen++;
                if (results_seen == RX_HOLD_AT)
                    hold_left = RX_HOLD_CYCLES;
                if ((results_seen % 256) < 64)
                    recv_stall = 0;
                else
                    recv_stall = $urandom_range(0, STALL_MAX);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                nxt_ready = 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                nxt_ready = 1'b0;
            end
            else
                nxt_ready = 1'b1;
            m_tready <= nxt_ready;
        end
    end

    initial
    begin
        int idle_run;
        idle_run = 0;
        while (idle_run < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("ps2_set2_key_tracker_tb NOT OK");
        $finish;
    end

    task automatic push_item(input logic [1:0] op, input logic [7:0] sb, input logic [6:0] qk);
        stim_t s;
        s.kind           = ST_ITEM;
        s.item.op        = op;
        s.item.scan_byte = sb;
        s.item.query_key = qk;
        s.cfg            = '0;
        s.gap            = (burst != 0) ? 0 : $urandom_range(0, STALL_MAX);
        stim_q.push_back(s);
        items_queued++;
    endtask

    task automatic push_ctrl(input stim_kind_t kind, input logic [15:0] value);
        stim_t s;
        s.kind = kind;
        s.item = '0;
        s.cfg  = value;
        s.gap  = 0;
        stim_q.push_back(s);
    endtask

    task automatic push_event(input logic [7:0] code, input logic ext, input logic brk);
        if (ext)
            push_item(OP_SCAN, PREFIX_EXT, 7'($urandom_range(0, 127)));
        if (brk)
            push_item(OP_SCAN, PREFIX_BRK, 7'($urandom_range(0, 127)));
        push_item(OP_SCAN, code, 7'($urandom_range(0, 127)));
    endtask

    function automatic logic [7:0] random_mapped_code();
        logic [7:0] code;
        do
            code = 8'($urandom_range(0, 255));
        while (set2_ascii(code) == 7'h00);
        return code;
    endfunction

    function automatic logic [7:0] random_arrow();
        case ($urandom_range(0, 3))
            0:       return SC_UP;
            1:       return SC_DOWN;
            2:       return SC_LEFT;
            default: return SC_RIGHT;
        endcase
    endfunction

    task automatic push_random_step();
        int         pick;
        logic       ext;
        logic [7:0] code;
        logic [6:0] qk;
        pick = $urandom_range(0, 99);
        if (pick < 65)
        begin
            ext = ($urandom_range(0, 2) == 0);
            if (ext && $urandom_range(0, 1) == 1)
                code = random_arrow();
            else
                code = random_mapped_code();
            push_event(code, ext, 1'($urandom_range(0, 1)));
        end
        else if (pick < 80)
            push_item(OP_TICK, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
        else if (pick < 90)
        begin
            case ($urandom_range(0, 2))
                0:       qk = 7'($urandom_range(0, 127));
                1:       qk = key_ascii(1'b1, random_arrow());
                default: qk = set2_ascii(random_mapped_code());
            endcase
            push_item(OP_QUERY, 8'($urandom_range(0, 255)), qk);
        end
        else if (pick < 97)
            push_item(OP_SCAN, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
        else
            push_item(OP_UNUSED, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
    endtask

    initial
    begin
        logic [15:0] phase_cfg [6];
        int target;
        phase_cfg[0] = 16'd0;
        phase_cfg[1] = 16'd3;
        phase_cfg[2] = 16'hFFFF;
        phase_cfg[3] = 16'd1;
        phase_cfg[4] = 16'd12;
        phase_cfg[5] = 16'($urandom_range(2, 40));

        // directed, with the hold-off at its reset value
        push_item(OP_QUERY, 8'h00, 7'h00);
        push_item(OP_QUERY, 8'hFF, 7'h7F);
        push_event(8'h1C, 1'b0, 1'b0);
        push_event(8'h1B, 1'b0, 1'b0);
        push_item(OP_QUERY, 8'h00, 7'h41);
        push_event(8'h1C, 1'b0, 1'b1);
        push_event(SC_UP, 1'b1, 1'b0);
        push_item(OP_TICK, 8'hFF, 7'h7F);
        push_event(SC_UP, 1'b1, 1'b1);
        push_event(PREFIX_EXT, 1'b1, 1'b0);
        push_event(PREFIX_EXT, 1'b0, 1'b1);
        push_event(PREFIX_BRK, 1'b0, 1'b1);
        push_item(OP_SCAN, 8'h00, 7'h7F);
        push_item(OP_SCAN, 8'hFF, 7'h00);
        push_item(OP_UNUSED, 8'hFF, 7'h7F);
        push_event(8'h1C, 1'b1, 1'b0);
        push_item(OP_QUERY, 8'h00, 7'h5E);

        for (int p = 0; p < 6; p++)
        begin
            push_ctrl(ST_CFG, phase_cfg[p]);
            if (p == 0)
            begin
                // zero hold-off accepts every press
                push_event(8'h1B, 1'b0, 1'b0);
                push_event(SC_LEFT, 1'b1, 1'b0);
                push_item(OP_QUERY, 8'h00, 7'h3C);
                push_event(SC_RIGHT, 1'b1, 1'b1);
            end
            target = items_queued + PHASE_ITEMS;
            burst = 1;
            while (items_queued < target)
            begin
                if (items_queued > target - PHASE_ITEMS + BURST_ITEMS)
                    burst = 0;
                push_random_step();
                if ($urandom_range(0, 99) == 0)
                    push_ctrl(ST_DRAIN, '0);
            end
            push_ctrl(ST_DRAIN, '0);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (stim_q.size() != 0 || s_tvalid || cfg_valid || tracker_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0 && tracker_results.size() == 0)
            $display("ps2_set2_key_tracker_tb OK");
        else
            $display("ps2_set2_key_tracker_tb NOT OK");
        $finish;
    end

endmodule
